// File: src/mmtp_pkg.sv
`default_nettype none
package mmtp_pkg;

  localparam int DVD_W = 28;
  localparam logic [DVD_W-1:0] WHOLE_NOTE_US = 28'd240000000;

  localparam int NUMBER_BITS_DEF = 16;
  localparam int DOT_LIMIT_DEF   = 31;
  localparam int VOLUME_MAX_DEF  = 100;

  localparam logic [6:0]  NOTE_COUNT = 7'd84;
  localparam logic [7:0]  TEMPO_MIN  = 8'd32;
  localparam logic [7:0]  TEMPO_MAX  = 8'd255;
  localparam logic [2:0]  OCTAVE_MAX = 3'd6;
  localparam logic [23:0] DUR_MAX    = 24'hFFFFFF;

  localparam logic [1:0] ST_NOTE   = 2'd0;
  localparam logic [1:0] ST_STOP   = 2'd1;
  localparam logic [1:0] ST_REPEAT = 2'd2;
  localparam logic [1:0] ST_ERROR  = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] freq;
    logic [23:0] dur;
    logic [23:0] sil;
    logic [6:0]  level;
  } res_t;

  // floor(880 * 2^((n-46)/12)) for notes 1..84
  localparam logic [12:0] FREQ_ROM [0:83] = '{
    13'd65,   13'd69,   13'd73,   13'd77,   13'd82,   13'd87,
    13'd92,   13'd97,   13'd103,  13'd110,  13'd116,  13'd123,
    13'd130,  13'd138,  13'd146,  13'd155,  13'd164,  13'd174,
    13'd184,  13'd195,  13'd207,  13'd220,  13'd233,  13'd246,
    13'd261,  13'd277,  13'd293,  13'd311,  13'd329,  13'd349,
    13'd369,  13'd391,  13'd415,  13'd440,  13'd466,  13'd493,
    13'd523,  13'd554,  13'd587,  13'd622,  13'd659,  13'd698,
    13'd739,  13'd783,  13'd830,  13'd880,  13'd932,  13'd987,
    13'd1046, 13'd1108, 13'd1174, 13'd1244, 13'd1318, 13'd1396,
    13'd1479, 13'd1567, 13'd1661, 13'd1760, 13'd1864, 13'd1975,
    13'd2093, 13'd2217, 13'd2349, 13'd2489, 13'd2637, 13'd2793,
    13'd2959, 13'd3135, 13'd3322, 13'd3520, 13'd3729, 13'd3951,
    13'd4186, 13'd4434, 13'd4698, 13'd4978, 13'd5274, 13'd5587,
    13'd5919, 13'd6271, 13'd6644, 13'd7040, 13'd7458, 13'd7902
  };

  // semitone offset of letters A..G within an octave that starts at C
  function automatic logic [3:0] semitone_of(input logic [2:0] letter);
    logic [3:0] s;
    unique case (letter)
      3'd0:    s = 4'd9;
      3'd1:    s = 4'd11;
      3'd2:    s = 4'd0;
      3'd3:    s = 4'd2;
      3'd4:    s = 4'd4;
      3'd5:    s = 4'd5;
      3'd6:    s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: src/music_macro_tune_parser.sv
`default_nettype none
// Music-macro tune parser.
// Feed the tune one ASCII character per input request (in_valid/in_ch, held
// by in_stall); a 0 character marks the end of the string. Each character
// yields zero, one or two result requests on the out_ channel (status,
// frequency, duration, silence, level), with out_final_res set on the last
// one caused by that character. A note or rest is resolved by the first
// character that cannot extend it, so results lag the note by one character.
// A character that resolves a note or rest makes two passes through the
// shared bit-serial divider (load, 28 quotient bits, done; whole note by
// tempo, then by length), then adds a halving extension once per dot.
// in_stall stays high until every result of the character sits in the output
// register or has been taken; one character is in work at a time.
// A stalled result holds in the output register; the parser holds in_stall
// until it can hand over the next one.
// Reset clears the parser, restores octave 4, tempo 120, length 4, normal
// mode and volume 100. Write the default registers over the cfg_ port
// (byte address 4 * register index) only while the block is idle.
module music_macro_tune_parser #(
  parameter int NUMBER_BITS = mmtp_pkg::NUMBER_BITS_DEF,
  parameter int DOT_LIMIT   = mmtp_pkg::DOT_LIMIT_DEF,
  parameter int VOLUME_MAX  = mmtp_pkg::VOLUME_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [12:0]      out_frequency_hz,
  output logic [23:0]      out_duration_us,
  output logic [23:0]      out_silence_us,
  output logic [6:0]       out_level,
  output logic             out_final_res,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int NB = NUMBER_BITS;
  localparam int LW = (NUMBER_BITS > 16) ? NUMBER_BITS : 16;
  localparam int NW = NUMBER_BITS + 4;
  localparam int DW = mmtp_pkg::DVD_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PARSE = 4'd1;
  localparam logic [3:0] S_D1GO  = 4'd2;
  localparam logic [3:0] S_D1W   = 4'd3;
  localparam logic [3:0] S_D2GO  = 4'd4;
  localparam logic [3:0] S_D2W   = 4'd5;
  localparam logic [3:0] S_GAP   = 4'd6;
  localparam logic [3:0] S_DOT   = 4'd7;
  localparam logic [3:0] S_PUT   = 4'd8;
  localparam logic [3:0] S_DRAIN = 4'd9;

  // parser phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_MODESEL = 3'd1;
  localparam logic [2:0] PH_ACCID   = 3'd2;
  localparam logic [2:0] PH_NUMBER  = 3'd3;
  localparam logic [2:0] PH_DOTS    = 3'd4;

  // pending command kinds
  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_LEN   = 3'd1;
  localparam logic [2:0] K_OCT   = 3'd2;
  localparam logic [2:0] K_TEMPO = 3'd3;
  localparam logic [2:0] K_PAUSE = 3'd4;
  localparam logic [2:0] K_NNOTE = 3'd5;
  localparam logic [2:0] K_TONE  = 3'd6;

  // articulation modes
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_LEGATO   = 2'd1;
  localparam logic [1:0] MODE_STACCATO = 2'd2;

  // register indexes
  localparam logic [2:0] REG_LENGTH = 3'd0;
  localparam logic [2:0] REG_OCTAVE = 3'd1;
  localparam logic [2:0] REG_TEMPO  = 3'd2;
  localparam logic [2:0] REG_MODE   = 3'd3;
  localparam logic [2:0] REG_VOLUME = 3'd4;

  localparam logic [NB-1:0] NUM_MAX = '1;

  // configuration registers
  logic [7:0] dlen_r, dlen_nxt;
  logic [2:0] doct_r, doct_nxt;
  logic [7:0] dtempo_r, dtempo_nxt;
  logic [1:0] dmode_r, dmode_nxt;
  logic [6:0] vol_r, vol_nxt;

  // parser state
  logic [3:0]    state_r, state_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic [NB-1:0] accum_r, accum_nxt;
  logic [4:0]    dots_r, dots_nxt;
  logic [6:0]    note_r, note_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [2:0]    oct_r, oct_nxt;
  logic [7:0]    tempo_r, tempo_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          rep_r, rep_nxt;
  logic          halt_r, halt_nxt;

  // timing datapath
  logic [LW-1:0] elen_r, elen_nxt;
  logic          rest_r, rest_nxt;
  logic [24:0]   p_r, p_nxt;
  logic [23:0]   ext_r, ext_nxt;
  logic [23:0]   sil_r, sil_nxt;
  logic [4:0]    dcnt_r, dcnt_nxt;

  // result slots and output register
  mmtp_pkg::res_t slot_r [2];
  mmtp_pkg::res_t slot_nxt [2];
  logic [1:0]     rcnt_r, rcnt_nxt;
  logic           idx_r, idx_nxt;
  mmtp_pkg::res_t out_res_r, out_res_nxt;
  logic           out_final_r, out_final_nxt;
  logic           out_valid_r, out_valid_nxt;

  // shared divider
  logic          div_start;
  logic [DW-1:0] div_dvd;
  logic [LW-1:0] div_dvs;
  logic          div_done;
  logic [DW-1:0] div_q;

  logic [7:0]    tempo_cl;
  logic [LW-1:0] elen_nz;
  logic [6:0]    vol_cl;

  assign tempo_cl = (tempo_r < mmtp_pkg::TEMPO_MIN) ? mmtp_pkg::TEMPO_MIN : tempo_r;
  assign elen_nz  = (elen_r == '0) ? LW'(1) : elen_r;
  assign vol_cl   = ({1'b0, vol_r} > 8'(VOLUME_MAX)) ? 7'(VOLUME_MAX) : vol_r;

  assign div_start = (state_r == S_D1GO) || (state_r == S_D2GO);
  assign div_dvd   = (state_r == S_D2GO) ? div_q : mmtp_pkg::WHOLE_NOTE_US;
  assign div_dvs   = (state_r == S_D2GO) ? elen_nz : LW'(tempo_cl);

  mmtp_div #(
    .DVD_W (DW),
    .DVS_W (LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  function automatic mmtp_pkg::res_t mk_res(input logic [1:0] st, input logic [12:0] f,
                                            input logic [23:0] d, input logic [23:0] s,
                                            input logic [6:0] lv);
    mmtp_pkg::res_t r;
    r.status = st;
    r.freq   = f;
    r.dur    = d;
    r.sil    = s;
    r.level  = (f == '0 || d == '0) ? 7'd0 : lv;
    return r;
  endfunction

  // configuration port
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    dlen_nxt   = dlen_r;
    doct_nxt   = doct_r;
    dtempo_nxt = dtempo_r;
    dmode_nxt  = dmode_r;
    vol_nxt    = vol_r;
    cfg_prdata = '0;
    unique case (cfg_paddr[4:2])
      REG_LENGTH: cfg_prdata = 32'(dlen_r);
      REG_OCTAVE: cfg_prdata = 32'(doct_r);
      REG_TEMPO:  cfg_prdata = 32'(dtempo_r);
      REG_MODE:   cfg_prdata = 32'(dmode_r);
      REG_VOLUME: cfg_prdata = 32'(vol_r);
      default:    cfg_prdata = '0;
    endcase
    if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_LENGTH: dlen_nxt   = cfg_pwdata[7:0];
        REG_OCTAVE: doct_nxt   = cfg_pwdata[2:0];
        REG_TEMPO:  dtempo_nxt = cfg_pwdata[7:0];
        REG_MODE:   dmode_nxt  = cfg_pwdata[1:0];
        REG_VOLUME: vol_nxt    = cfg_pwdata[6:0];
        default:    ;
      endcase
    end
  end

  // sequencer and parser
  logic [7:0]    c;
  logic [7:0]    c_in;
  logic          is_digit;
  logic [NW-1:0] num_v;
  logic          do_fail;
  logic          do_end;
  logic          done;
  logic          put_en;
  mmtp_pkg::res_t put_res;
  logic [23:0]   base;
  logic [23:0]   gap;
  logic [23:0]   per;
  logic [23:0]   dsat;
  logic [2:0]    oc;
  logic          out_load;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    accum_nxt     = accum_r;
    dots_nxt      = dots_r;
    note_nxt      = note_r;
    len_nxt       = len_r;
    oct_nxt       = oct_r;
    tempo_nxt     = tempo_r;
    mode_nxt      = mode_r;
    rep_nxt       = rep_r;
    halt_nxt      = halt_r;
    elen_nxt      = elen_r;
    rest_nxt      = rest_r;
    p_nxt         = p_r;
    ext_nxt       = ext_r;
    sil_nxt       = sil_r;
    dcnt_nxt      = dcnt_r;
    slot_nxt      = slot_r;
    rcnt_nxt      = rcnt_r;
    idx_nxt       = idx_r;
    out_res_nxt   = out_res_r;
    out_final_nxt = out_final_r;
    out_valid_nxt = out_valid_r && out_stall;
    do_fail       = 1'b0;
    do_end        = 1'b0;
    done          = 1'b0;
    put_en        = 1'b0;
    put_res       = '0;
    c             = ch_r;
    is_digit      = (c >= "0") && (c <= "9");
    num_v         = (NW'(accum_r) << 3) + (NW'(accum_r) << 1) + NW'(c - "0");
    oc            = (oct_r > mmtp_pkg::OCTAVE_MAX) ? mmtp_pkg::OCTAVE_MAX : oct_r;
    base          = 24'(div_q);
    gap           = '0;
    per           = '0;
    dsat          = p_r[24] ? mmtp_pkg::DUR_MAX : p_r[23:0];
    c_in          = in_ch;
    out_load      = !out_valid_r || !out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // drop everything up to the end marker after an error
          if (halt_r) begin
            if (in_ch == 8'd0) halt_nxt = 1'b0;
          end else if (!(in_ch == " " || (in_ch >= 8'd9 && in_ch <= 8'd13))) begin
            if (in_ch >= "a" && in_ch <= "z") c_in = in_ch - 8'd32;
            ch_nxt    = c_in;
            state_nxt = S_PARSE;
          end
        end
      end

      S_PARSE: begin
        unique case (phase_r)
          PH_MODESEL: begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
            priority if (c == "N") mode_nxt = MODE_NORMAL;
            else if (c == "L") mode_nxt = MODE_LEGATO;
            else if (c == "S") mode_nxt = MODE_STACCATO;
            else if (c == "F") rep_nxt = 1'b0;
            else if (c == "B") rep_nxt = 1'b1;
            else do_fail = 1'b1;
          end
          PH_ACCID: begin
            phase_nxt = PH_NUMBER;
            accum_nxt = '0;
            if (c == "#" || c == "+") begin
              if (note_r < mmtp_pkg::NOTE_COUNT) note_nxt = note_r + 7'd1;
              done = 1'b1;
            end else if (c == "-") begin
              if (note_r > 7'd1) note_nxt = note_r - 7'd1;
              done = 1'b1;
            end
          end
          PH_NUMBER: begin
            if (is_digit) begin
              accum_nxt = (num_v > NW'(NUM_MAX)) ? NUM_MAX : num_v[NB-1:0];
              done      = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
              if (kind_r == K_LEN) begin
                if (accum_r == '0) do_fail = 1'b1;
                else len_nxt = (LW'(accum_r) > LW'(16'hFFFF)) ? 16'hFFFF : 16'(accum_r);
              end else if (kind_r == K_OCT) begin
                oct_nxt = (accum_r > NB'(mmtp_pkg::OCTAVE_MAX)) ?
                          mmtp_pkg::OCTAVE_MAX : accum_r[2:0];
              end else if (kind_r == K_TEMPO) begin
                if (accum_r >= NB'(mmtp_pkg::TEMPO_MIN) && accum_r <= NB'(mmtp_pkg::TEMPO_MAX))
                  tempo_nxt = accum_r[7:0];
                else
                  do_fail = 1'b1;
              end else if (kind_r == K_NNOTE && accum_r > NB'(mmtp_pkg::NOTE_COUNT)) begin
                do_fail = 1'b1;
              end else if (kind_r == K_PAUSE || kind_r == K_NNOTE || kind_r == K_TONE) begin
                if (kind_r == K_NNOTE) note_nxt = accum_r[6:0];
                dots_nxt  = '0;
                phase_nxt = PH_DOTS;
              end
            end
          end
          PH_DOTS: begin
            if (c == ".") begin
              if (dots_r < 5'(DOT_LIMIT)) dots_nxt = dots_r + 5'd1;
              done = 1'b1;
            end else if (kind_r == K_PAUSE) begin
              rest_nxt  = 1'b1;
              elen_nxt  = LW'(accum_r);
              state_nxt = S_D1GO;
            end else if (kind_r == K_NNOTE && note_r == '0) begin
              rest_nxt  = 1'b1;
              elen_nxt  = LW'(len_r);
              state_nxt = S_D1GO;
            end else if (note_r == '0 || note_r > mmtp_pkg::NOTE_COUNT) begin
              // nothing to sound: resolve and handle the character as a command
              phase_nxt = PH_IDLE;
              kind_nxt  = K_NONE;
            end else begin
              rest_nxt  = 1'b0;
              elen_nxt  = (kind_r == K_TONE && accum_r != '0) ? LW'(accum_r) : LW'(len_r);
              state_nxt = S_D1GO;
            end
          end
          default: begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
            kind_nxt  = K_NONE;
            priority if (c == 8'd0) begin
              do_end = 1'b1;
            end else if (c == "<") begin
              if (oct_r > 3'd0) oct_nxt = oct_r - 3'd1;
            end else if (c == ">") begin
              if (oct_r < mmtp_pkg::OCTAVE_MAX) oct_nxt = oct_r + 3'd1;
            end else if (c == "L" || c == "O" || c == "T" || c == "P" || c == "N") begin
              accum_nxt = '0;
              phase_nxt = PH_NUMBER;
              priority if (c == "L") kind_nxt = K_LEN;
              else if (c == "O") kind_nxt = K_OCT;
              else if (c == "T") kind_nxt = K_TEMPO;
              else if (c == "P") kind_nxt = K_PAUSE;
              else kind_nxt = K_NNOTE;
            end else if (c == "M") begin
              phase_nxt = PH_MODESEL;
            end else if (c >= "A" && c <= "G") begin
              note_nxt  = 7'(mmtp_pkg::semitone_of(3'(c - "A"))) + 7'(oc) * 7'd12 + 7'd1;
              kind_nxt  = K_TONE;
              phase_nxt = PH_ACCID;
            end else begin
              do_fail = 1'b1;
            end
          end
        endcase

        if (do_end) begin
          put_en  = 1'b1;
          put_res = mk_res(rep_r ? mmtp_pkg::ST_REPEAT : mmtp_pkg::ST_STOP,
                           '0, '0, '0, vol_cl);
        end
        if (do_fail) begin
          done     = 1'b1;
          rep_nxt  = 1'b0;
          halt_nxt = (c != 8'd0);
          put_en   = 1'b1;
          put_res  = mk_res(mmtp_pkg::ST_ERROR, '0, '0, '0, vol_cl);
        end
        // restore the defaults after an end marker or an error
        if (do_end || do_fail) begin
          phase_nxt = PH_IDLE;
          kind_nxt  = K_NONE;
          accum_nxt = '0;
          dots_nxt  = '0;
          note_nxt  = '0;
          len_nxt   = 16'(dlen_r);
          oct_nxt   = (doct_r > mmtp_pkg::OCTAVE_MAX) ? mmtp_pkg::OCTAVE_MAX : doct_r;
          tempo_nxt = (dtempo_r < mmtp_pkg::TEMPO_MIN) ? mmtp_pkg::TEMPO_MIN : dtempo_r;
          mode_nxt  = dmode_r;
        end
        if (put_en) begin
          slot_nxt[rcnt_r[0]] = put_res;
          rcnt_nxt            = rcnt_r + 2'd1;
        end
        if (done) begin
          idx_nxt   = 1'b0;
          state_nxt = (rcnt_nxt != 2'd0) ? S_DRAIN : S_IDLE;
        end
      end

      S_D1GO: state_nxt = S_D1W;
      S_D1W:  if (div_done) state_nxt = S_D2GO;
      S_D2GO: state_nxt = S_D2W;
      S_D2W:  if (div_done) state_nxt = S_GAP;

      S_GAP: begin
        // take the articulation gap out of the period; rests keep it all
        if (!rest_r) begin
          unique case (mode_r)
            MODE_NORMAL:   gap = base >> 3;
            MODE_STACCATO: gap = base >> 2;
            default:       gap = '0;
          endcase
        end
        per       = base - gap;
        sil_nxt   = gap;
        p_nxt     = {1'b0, per};
        ext_nxt   = per >> 1;
        dcnt_nxt  = dots_r;
        state_nxt = S_DOT;
      end

      S_DOT: begin
        // each dot adds a halving extension
        if (dcnt_r != '0) begin
          p_nxt    = p_r + 25'(ext_r);
          ext_nxt  = ext_r >> 1;
          dcnt_nxt = dcnt_r - 5'd1;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        if (rest_r)
          put_res = mk_res(mmtp_pkg::ST_NOTE, '0, '0, dsat, vol_cl);
        else
          put_res = mk_res(mmtp_pkg::ST_NOTE, mmtp_pkg::FREQ_ROM[note_r - 7'd1],
                           dsat, sil_r, vol_cl);
        slot_nxt[rcnt_r[0]] = put_res;
        rcnt_nxt            = rcnt_r + 2'd1;
        phase_nxt           = PH_IDLE;
        kind_nxt            = K_NONE;
        state_nxt           = S_PARSE;
      end

      S_DRAIN: begin
        if (out_load) begin
          out_res_nxt   = slot_r[idx_r];
          out_final_nxt = ({1'b0, idx_r} == rcnt_r - 2'd1);
          out_valid_nxt = 1'b1;
          if ({1'b0, idx_r} == rcnt_r - 2'd1) begin
            rcnt_nxt  = '0;
            idx_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = 1'b1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlen_r      <= 8'd4;
      doct_r      <= 3'd4;
      dtempo_r    <= 8'd120;
      dmode_r     <= MODE_NORMAL;
      vol_r       <= 7'd100;
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      kind_r      <= K_NONE;
      accum_r     <= '0;
      dots_r      <= '0;
      note_r      <= '0;
      len_r       <= 16'd4;
      oct_r       <= 3'd4;
      tempo_r     <= 8'd120;
      mode_r      <= MODE_NORMAL;
      rep_r       <= 1'b0;
      halt_r      <= 1'b0;
      rcnt_r      <= '0;
      idx_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dlen_r      <= dlen_nxt;
      doct_r      <= doct_nxt;
      dtempo_r    <= dtempo_nxt;
      dmode_r     <= dmode_nxt;
      vol_r       <= vol_nxt;
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      accum_r     <= accum_nxt;
      dots_r      <= dots_nxt;
      note_r      <= note_nxt;
      len_r       <= len_nxt;
      oct_r       <= oct_nxt;
      tempo_r     <= tempo_nxt;
      mode_r      <= mode_nxt;
      rep_r       <= rep_nxt;
      halt_r      <= halt_nxt;
      rcnt_r      <= rcnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ch_r        <= ch_nxt;
    elen_r      <= elen_nxt;
    rest_r      <= rest_nxt;
    p_r         <= p_nxt;
    ext_r       <= ext_nxt;
    sil_r       <= sil_nxt;
    dcnt_r      <= dcnt_nxt;
    slot_r      <= slot_nxt;
    out_res_r   <= out_res_nxt;
    out_final_r <= out_final_nxt;
  end

  // accept only between characters
  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_frequency_hz = out_res_r.freq;
  assign out_duration_us  = out_res_r.dur;
  assign out_silence_us   = out_res_r.sil;
  assign out_level        = out_res_r.level;
  assign out_final_res    = out_final_r;

  a_slots_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r != 2'd3)
    else $error("more than two results buffered for one character");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_D1W || state_r == S_D2W))
    else $error("divider finished while sequencer was not waiting");

  a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (phase_r == PH_IDLE && kind_r == K_NONE))
    else $error("parser holds a pending command while skipping after an error");

  a_params_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    oct_r <= mmtp_pkg::OCTAVE_MAX && tempo_r >= mmtp_pkg::TEMPO_MIN)
    else $error("octave or tempo out of range");

  a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (rcnt_r != 2'd0))
    else $error("draining with no buffered result");

endmodule
`default_nettype wire

// File: src/mmtp_div.sv
`default_nettype none
module mmtp_div #(
  parameter int DVD_W = mmtp_pkg::DVD_W,
  parameter int DVS_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, q_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CW'(DVD_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      q_nxt    = {q_r[DVD_W-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire
